FILE: rtl/urirep_pkg.sv
// ----------------------------------------------------------------------------
// urirep_pkg
// Shared types and constants for the URI-to-IRI repercent core: beat
// structs, sequencer and escape-phase enums, byte class record and the
// emit request passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
package urirep_pkg;

  // Input and output beats
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // Character codes
  localparam logic [7:0] ChPct = 8'h25;

  // Output bytes kept per input byte; later ones are dropped
  localparam logic [4:0] MaxPuts = 5'd24;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_END_PCT,
    ST_END_HELD,
    ST_END_QUOTE,
    ST_FLUSH
  } st_e;

  // Percent-escape phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIGIT
  } ph_e;

  // UTF-8 lead byte class
  typedef enum logic [2:0] {
    LD_ASCII,
    LD_TWO,
    LD_THREE,
    LD_FOUR,
    LD_BAD
  } lead_e;

  // Classification of one byte
  typedef struct packed {
    logic       is_hex;
    logic [3:0] hex_nib;
    logic       unres;
    logic       safe;
    lead_e      lead;
  } cls_t;

  // Emit request: load up to four bytes, or flush the held byte
  typedef struct packed {
    logic            load;
    logic            flush;
    logic            last;
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } em_req_t;

endpackage

FILE: rtl/urirep_cls.sv
// ----------------------------------------------------------------------------
// urirep_cls
// Byte classifier: hex digit value, unreserved and safe-set membership,
// and UTF-8 lead byte class.
// ----------------------------------------------------------------------------
module urirep_cls (
  input  logic [7:0]       byte_i,
  output urirep_pkg::cls_t cls_o
);

  always_comb begin
    cls_o = '0;

    // Hex digit, either case
    if (byte_i inside {[8'h30:8'h39]}) begin
      cls_o.is_hex  = 1'b1;
      cls_o.hex_nib = byte_i[3:0];
    end else if (byte_i inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      cls_o.is_hex  = 1'b1;
      cls_o.hex_nib = byte_i[3:0] + 4'd9;
    end

    // Unreserved ASCII: letters, digits, - . _ ~
    cls_o.unres = byte_i inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                                 8'h2D, 8'h2E, 8'h5F, 8'h7E};

    // Reserved characters allowed raw in the IRI
    cls_o.safe = byte_i inside {8'h2F, 8'h23, 8'h25, 8'h5B, 8'h5D, 8'h3D, 8'h3A,
                                8'h3B, 8'h24, 8'h26, 8'h28, 8'h29, 8'h2B, 8'h2C,
                                8'h21, 8'h3F, 8'h2A, 8'h40, 8'h27, 8'h7E};

    // UTF-8 lead class
    if (!byte_i[7]) begin
      cls_o.lead = urirep_pkg::LD_ASCII;
    end else if (byte_i[7:5] == 3'b110) begin
      cls_o.lead = urirep_pkg::LD_TWO;
    end else if (byte_i[7:4] == 4'b1110) begin
      cls_o.lead = urirep_pkg::LD_THREE;
    end else if (byte_i[7:3] == 5'b11110) begin
      cls_o.lead = urirep_pkg::LD_FOUR;
    end else begin
      cls_o.lead = urirep_pkg::LD_BAD;
    end
  end

endmodule

FILE: rtl/urirep_emit.sv
// ----------------------------------------------------------------------------
// urirep_emit
// Output stage: drains a small byte buffer one byte a cycle, unless the output
// stalls, through a one-byte holding register so that the final byte of an
// input can be marked last, caps the bytes kept per input, drives the output beat.
// ----------------------------------------------------------------------------
module urirep_emit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  urirep_pkg::em_req_t     req_i,
  output logic                    busy_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output urirep_pkg::out_beat_t   out_beat_o
);

  logic [3:0][7:0]       buf_q, buf_d;
  logic [2:0]            bcnt_q, bcnt_d;
  logic [1:0]            bidx_q, bidx_d;
  logic                  flush_pend_q, flush_pend_d;
  logic                  flush_last_q, flush_last_d;
  logic [7:0]            hold_q, hold_d;
  logic                  hold_vld_q, hold_vld_d;
  logic [4:0]            put_cnt_q, put_cnt_d;
  logic                  out_vld_q, out_vld_d;
  urirep_pkg::out_beat_t out_q, out_d;
  logic                  out_free;
  logic                  mv;
  logic                  mv_last;
  logic                  adv;

  // Drain buffer, move held byte to the output register
  always_comb begin
    buf_d        = buf_q;
    bcnt_d       = bcnt_q;
    bidx_d       = bidx_q;
    flush_pend_d = flush_pend_q;
    flush_last_d = flush_last_q;
    hold_d       = hold_q;
    hold_vld_d   = hold_vld_q;
    put_cnt_d    = put_cnt_q;
    out_free     = !out_vld_q || !out_stall_i;
    mv           = 1'b0;
    mv_last      = 1'b0;
    adv          = 1'b0;

    if (bcnt_q != 3'd0) begin
      if (put_cnt_q >= urirep_pkg::MaxPuts) begin
        // drop bytes past the cap
        adv = 1'b1;
      end else if (!hold_vld_q || out_free) begin
        mv         = hold_vld_q;
        hold_d     = buf_q[bidx_q];
        hold_vld_d = 1'b1;
        put_cnt_d  = put_cnt_q + 5'd1;
        adv        = 1'b1;
      end
    end else if (flush_pend_q) begin
      if (!hold_vld_q) begin
        flush_pend_d = 1'b0;
        put_cnt_d    = '0;
      end else if (out_free) begin
        mv           = 1'b1;
        mv_last      = flush_last_q;
        hold_vld_d   = 1'b0;
        flush_pend_d = 1'b0;
        put_cnt_d    = '0;
      end
    end

    if (adv) begin
      bidx_d = bidx_q + 2'd1;
      bcnt_d = bcnt_q - 3'd1;
    end

    // Accept new work from the sequencer
    if (req_i.load) begin
      buf_d  = req_i.bytes;
      bcnt_d = req_i.cnt;
      bidx_d = '0;
    end
    if (req_i.flush) begin
      flush_pend_d = 1'b1;
      flush_last_d = req_i.last;
    end

    // Output register
    out_d = out_q;
    if (mv) begin
      out_vld_d      = 1'b1;
      out_d.out_byte = hold_q;
      out_d.out_last = mv_last;
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q       <= '0;
      bidx_q       <= '0;
      flush_pend_q <= 1'b0;
      hold_vld_q   <= 1'b0;
      put_cnt_q    <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      bcnt_q       <= bcnt_d;
      bidx_q       <= bidx_d;
      flush_pend_q <= flush_pend_d;
      hold_vld_q   <= hold_vld_d;
      put_cnt_q    <= put_cnt_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    buf_q        <= buf_d;
    flush_last_q <= flush_last_d;
    hold_q       <= hold_d;
    out_q        <= out_d;
  end

  assign busy_o      = (bcnt_q != 3'd0) || flush_pend_q;
  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

endmodule

FILE: rtl/uri_to_iri_utf8_repercent_core.sv
// ----------------------------------------------------------------------------
// uri_to_iri_utf8_repercent_core
// URI to IRI converter: selective percent-decoding followed by UTF-8
// checking, with rejected lead bytes and cut-short tails re-escaped.
//
//   channel | dir | handshake                 | beat
//   --------+-----+---------------------------+------------------------------
//   in      | in  | in_valid_i / in_stall_o   | in_byte, in_last
//   out     | out | out_valid_o / out_stall_i | out_byte, out_last
//
// One input byte at a time: one sequencer step per character scanned in either
// stage, 0..24 output bytes per input byte; in_last adds the tail steps for the
// escape and quoting. The emit stage moves one byte a cycle while the output
// is not stalled; the sequencer waits for it before each step, and each step
// uses the shared byte classifier, plus a second one for the decoded escape.
// Reset clears the sequencer, escape phase and UTF-8 counters; no pass.
// An output stall holds the output register and, once the holding byte is
// full, freezes the sequencer until the beat is taken.
// ----------------------------------------------------------------------------
module uri_to_iri_utf8_repercent_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  urirep_pkg::in_beat_t  in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output urirep_pkg::out_beat_t out_beat_o
);

  urirep_pkg::st_e     state_q, state_d;
  urirep_pkg::ph_e     phase_q, phase_d;
  logic                last_q, last_d;
  logic [1:0][7:0]     s1q_q, s1q_d;
  logic [1:0]          s1n_q, s1n_d;
  logic [7:0]          held1_q, held1_d;
  logic [3:0]          hi_q, hi_d;
  logic [3:0][7:0]     s2q_q, s2q_d;
  logic [2:0]          s2n_q, s2n_d;
  logic [3:0][7:0]     pend_q, pend_d;
  logic [2:0]          ucnt_q, ucnt_d;
  logic [2:0]          uneed_q, uneed_d;
  logic [2:0]          qk_q, qk_d;

  logic [7:0]          cur_b;
  logic [7:0]          dec_b;
  urirep_pkg::cls_t    cls_cur;
  urirep_pkg::cls_t    cls_dec;
  urirep_pkg::em_req_t em_req;
  logic                em_busy;
  logic [3:0][7:0]     pv;
  logic [2:0]          len;
  logic [2:0]          rsc;
  logic [2:0]          j;
  logic                seq_good;

  // Upper-case hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  // Single byte emit request
  function automatic urirep_pkg::em_req_t byte_req(input logic [7:0] b);
    urirep_pkg::em_req_t r;
    r          = '0;
    r.load     = 1'b1;
    r.cnt      = 3'd1;
    r.bytes[0] = b;
    return r;
  endfunction

  // %XX emit request
  function automatic urirep_pkg::em_req_t pct_req(input logic [7:0] b);
    urirep_pkg::em_req_t r;
    r          = '0;
    r.load     = 1'b1;
    r.cnt      = 3'd3;
    r.bytes[0] = urirep_pkg::ChPct;
    r.bytes[1] = hex_char(b[7:4]);
    r.bytes[2] = hex_char(b[3:0]);
    return r;
  endfunction

  // UTF-8 sequence check: continuations, overlong, surrogates, range
  function automatic logic seq_ok(input logic [3:0][7:0] p, input logic [2:0] n);
    logic        ok;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    cp2 = {p[0][4:0], p[1][5:0]};
    cp3 = {p[0][3:0], p[1][5:0], p[2][5:0]};
    cp4 = {p[0][2:0], p[1][5:0], p[2][5:0], p[3][5:0]};
    case (n)
      3'd2: ok = (p[1][7:6] == 2'b10) && (cp2 >= 11'h080);
      3'd3: ok = (p[1][7:6] == 2'b10) && (p[2][7:6] == 2'b10) &&
                 (cp3 >= 16'h0800) && !((cp3 >= 16'hD800) && (cp3 <= 16'hDFFF));
      3'd4: ok = (p[1][7:6] == 2'b10) && (p[2][7:6] == 2'b10) &&
                 (p[3][7:6] == 2'b10) && (cp4 >= 21'h10000) && (cp4 <= 21'h10FFFF);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Select the byte under work for the shared classifier
  always_comb begin
    if (s2n_q != 3'd0) begin
      cur_b = s2q_q[0];
    end else if (state_q == urirep_pkg::ST_END_QUOTE) begin
      cur_b = pend_q[qk_q[1:0]];
    end else begin
      cur_b = s1q_q[0];
    end
  end

  assign dec_b = {hi_q, cls_cur.hex_nib};

  urirep_cls u_cls_cur (
    .byte_i (cur_b),
    .cls_o  (cls_cur)
  );

  urirep_cls u_cls_dec (
    .byte_i (dec_b),
    .cls_o  (cls_dec)
  );

  // Pending sequence with the current byte written in
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pv[k] = (2'(k) == ucnt_q[1:0]) ? cur_b : pend_q[k];
    end
    len      = (uneed_q > 3'd4) ? 3'd4 : uneed_q;
    rsc      = (len != 3'd0) ? (len - 3'd1) : 3'd0;
    seq_good = seq_ok(pv, len);
  end

  // Sequencer: next state, queues and emit requests
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    last_d     = last_q;
    s1q_d      = s1q_q;
    s1n_d      = s1n_q;
    held1_d    = held1_q;
    hi_d       = hi_q;
    s2q_d      = s2q_q;
    s2n_d      = s2n_q;
    pend_d     = pend_q;
    ucnt_d     = ucnt_q;
    uneed_d    = uneed_q;
    qk_d       = qk_q;
    em_req     = '0;
    j          = '0;
    in_stall_o = (state_q != urirep_pkg::ST_IDLE);

    if (state_q == urirep_pkg::ST_IDLE) begin
      // take a new input byte
      if (in_valid_i) begin
        s1q_d[0] = in_beat_i.in_byte;
        s1n_d    = 2'd1;
        last_d   = in_beat_i.in_last;
        state_d  = urirep_pkg::ST_RUN;
      end
    end else if (state_q == urirep_pkg::ST_FLUSH) begin
      // release the held byte, marked last at the end of a URI
      if (!em_busy) begin
        em_req.flush = 1'b1;
        em_req.last  = last_q;
        state_d      = urirep_pkg::ST_IDLE;
      end
    end else if (!em_busy) begin
      if (s2n_q != 3'd0) begin
        // UTF-8 stage: pop one byte
        for (int i = 0; i < 3; i++) begin
          s2q_d[i] = s2q_q[i+1];
        end
        s2q_d[3] = '0;
        s2n_d    = s2n_q - 3'd1;
        if (ucnt_q == 3'd0) begin
          case (cls_cur.lead)
            urirep_pkg::LD_ASCII: em_req = byte_req(cur_b);
            urirep_pkg::LD_TWO: begin
              pend_d[0] = cur_b;
              ucnt_d    = 3'd1;
              uneed_d   = 3'd2;
            end
            urirep_pkg::LD_THREE: begin
              pend_d[0] = cur_b;
              ucnt_d    = 3'd1;
              uneed_d   = 3'd3;
            end
            urirep_pkg::LD_FOUR: begin
              pend_d[0] = cur_b;
              ucnt_d    = 3'd1;
              uneed_d   = 3'd4;
            end
            default: em_req = pct_req(cur_b);
          endcase
        end else begin
          pend_d = pv;
          ucnt_d = ucnt_q + 3'd1;
          if ((ucnt_q + 3'd1) >= uneed_q) begin
            if (seq_good) begin
              em_req.load  = 1'b1;
              em_req.cnt   = len;
              em_req.bytes = pv;
            end else begin
              // escape the lead, rescan the bytes after it
              em_req = pct_req(pv[0]);
              for (int i = 0; i < 4; i++) begin
                j = 3'(i) - rsc + 3'd1;
                if (3'(i) < rsc) begin
                  s2q_d[i] = pv[2'(i + 1)];
                end else if (j < 3'd4) begin
                  s2q_d[i] = s2q_q[j[1:0]];
                end else begin
                  s2q_d[i] = '0;
                end
              end
              s2n_d = s2n_q - 3'd1 + rsc;
            end
            ucnt_d  = '0;
            uneed_d = '0;
          end
        end
      end else begin
        case (state_q)
          urirep_pkg::ST_RUN: begin
            if (s1n_q != 2'd0) begin
              // percent stage: one character
              case (phase_q)
                urirep_pkg::PH_PCT: begin
                  if (cls_cur.is_hex) begin
                    held1_d  = cur_b;
                    hi_d     = cls_cur.hex_nib;
                    phase_d  = urirep_pkg::PH_DIGIT;
                    s1q_d[0] = s1q_q[1];
                    s1q_d[1] = '0;
                    s1n_d    = s1n_q - 2'd1;
                  end else begin
                    // pass '%' raw, scan this character again
                    s2q_d[0] = urirep_pkg::ChPct;
                    s2n_d    = 3'd1;
                    phase_d  = urirep_pkg::PH_IDLE;
                  end
                end
                urirep_pkg::PH_DIGIT: begin
                  phase_d = urirep_pkg::PH_IDLE;
                  if (cls_cur.is_hex && (cls_dec.unres || dec_b[7])) begin
                    s2q_d[0] = dec_b;
                    s2n_d    = 3'd1;
                    s1q_d[0] = s1q_q[1];
                    s1q_d[1] = '0;
                    s1n_d    = s1n_q - 2'd1;
                  end else begin
                    // pass '%' raw, rescan both digits
                    s2q_d[0] = urirep_pkg::ChPct;
                    s2n_d    = 3'd1;
                    s1q_d[0] = held1_q;
                    s1q_d[1] = cur_b;
                    s1n_d    = 2'd2;
                  end
                end
                default: begin
                  if (cur_b == urirep_pkg::ChPct) begin
                    phase_d = urirep_pkg::PH_PCT;
                  end else begin
                    s2q_d[0] = cur_b;
                    s2n_d    = 3'd1;
                  end
                  s1q_d[0] = s1q_q[1];
                  s1q_d[1] = '0;
                  s1n_d    = s1n_q - 2'd1;
                end
              endcase
            end else if (last_q) begin
              state_d = urirep_pkg::ST_END_PCT;
            end else begin
              state_d = urirep_pkg::ST_FLUSH;
            end
          end
          urirep_pkg::ST_END_PCT: begin
            // unfinished escape: '%' passes raw
            if (phase_q != urirep_pkg::PH_IDLE) begin
              s2q_d[0] = urirep_pkg::ChPct;
              s2n_d    = 3'd1;
            end
            state_d = urirep_pkg::ST_END_HELD;
          end
          urirep_pkg::ST_END_HELD: begin
            // unfinished escape: held digit passes raw
            if (phase_q == urirep_pkg::PH_DIGIT) begin
              s2q_d[0] = held1_q;
              s2n_d    = 3'd1;
            end
            phase_d = urirep_pkg::PH_IDLE;
            qk_d    = '0;
            state_d = urirep_pkg::ST_END_QUOTE;
          end
          urirep_pkg::ST_END_QUOTE: begin
            // cut-short sequence: quote each pending byte
            if (qk_q < ucnt_q) begin
              em_req = (cls_cur.unres || cls_cur.safe) ? byte_req(cur_b) : pct_req(cur_b);
              qk_d   = qk_q + 3'd1;
            end else begin
              ucnt_d  = '0;
              uneed_d = '0;
              held1_d = '0;
              hi_d    = '0;
              state_d = urirep_pkg::ST_FLUSH;
            end
          end
          default: state_d = urirep_pkg::ST_IDLE;
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= urirep_pkg::ST_IDLE;
      phase_q <= urirep_pkg::PH_IDLE;
      last_q  <= 1'b0;
      s1n_q   <= '0;
      held1_q <= '0;
      hi_q    <= '0;
      s2n_q   <= '0;
      ucnt_q  <= '0;
      uneed_q <= '0;
      qk_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      last_q  <= last_d;
      s1n_q   <= s1n_d;
      held1_q <= held1_d;
      hi_q    <= hi_d;
      s2n_q   <= s2n_d;
      ucnt_q  <= ucnt_d;
      uneed_q <= uneed_d;
      qk_q    <= qk_d;
    end
  end

  // Byte queues and pending sequence
  always_ff @(posedge clk_i) begin
    s1q_q  <= s1q_d;
    s2q_q  <= s2q_d;
    pend_q <= pend_d;
  end

  urirep_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (em_req),
    .busy_o      (em_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a byte was still in work");

  a_s2_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2n_q <= 3'd4)
    else $error("UTF-8 rescan queue overflow");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ucnt_q != 3'd0) |-> ((uneed_q > ucnt_q) && (uneed_q <= 3'd4)))
    else $error("pending UTF-8 count out of range");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == urirep_pkg::ST_IDLE) |-> ((s1n_q == 2'd0) && (s2n_q == 3'd0)))
    else $error("idle with bytes left in a queue");

  a_escape_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == urirep_pkg::ST_FLUSH) && last_q) |-> (phase_q == urirep_pkg::PH_IDLE))
    else $error("escape still pending at end of URI");

endmodule
